/* hw/rtl/sos_pkg.sv */
// ----------------------------------------------------------------------------
// sos_pkg
// Shared types and constants of the sweep object segmenter: field widths,
// detector and back end states, the object job record and fixed constants.
// ----------------------------------------------------------------------------
package sos_pkg;

   // field widths
   localparam int unsigned DIST_W   = 16;
   localparam int unsigned ANGLE_W  = 8;
   localparam int unsigned STEP_W   = 5;
   localparam int unsigned SUM_W    = 23;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned FOUND_W  = 6;

   // saturation limits
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
   localparam logic [FOUND_W-1:0] FOUND_MAX  = 6'd63;
   localparam logic [ANGLE_W-1:0] SIZE_LIMIT = 8'd180;

   // tangent arithmetic
   localparam int unsigned TAN_W      = 24;
   localparam int unsigned TRIG_W     = 31;
   localparam int unsigned FRAC_SHIFT = 16;
   localparam int unsigned Q30_SHIFT  = 30;
   localparam logic [63:0] ROUND_Q30    = 64'd1 << (Q30_SHIFT - 1);
   localparam logic [63:0] ONE_Q30      = 64'd1 << Q30_SHIFT;
   localparam logic [63:0] COS_HALF_Q30 = 64'd1073700939;
   localparam logic [63:0] SIN_HALF_Q30 = 64'd9370046;
   localparam int unsigned PROD_W     = DIST_W + TAN_W;

   // serial divider
   localparam int unsigned DIV_NUM_W  = 46;
   localparam int unsigned DIV_DEN_W  = 31;
   localparam int unsigned DIV_STEP_W = 6;
   localparam logic [DIV_STEP_W-1:0] MEAN_STEPS = 6'd23;
   localparam logic [DIV_STEP_W-1:0] TAN_STEPS  = 6'd46;

   // configuration registers
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_STEP     = 1'd1;
   localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd1600;
   localparam logic [STEP_W-1:0] STEP_RESET      = 5'd2;

   // job queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      DET_IDLE     = 3'd0,
      DET_FIRST    = 3'd1,
      DET_SECOND   = 3'd2,
      DET_COUNTED  = 3'd3,
      DET_REJECTED = 3'd4,
      DET_CONTINUE = 3'd5,
      DET_ENDED    = 3'd6
   } det_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MEAN,
      BK_TAN,
      BK_MUL,
      BK_WIDTH,
      BK_OUT
   } back_state_type;

   // one finished object handed from front to back
   typedef struct packed {
      logic [FOUND_W-1:0] found;
      logic [ANGLE_W-1:0] last;
      logic [ANGLE_W-1:0] run_begin;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } job_type;

endpackage

/* hw/rtl/sos_front.sv */
// ----------------------------------------------------------------------------
// sos_front
// Classifies each sample as near or far, runs the object detector and
// pushes one job per finished object into the queue.
// ----------------------------------------------------------------------------
module sos_front import sos_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_sweep_start,
   input  logic [ANGLE_W-1:0] req_angle,
   input  logic [DIST_W-1:0]  req_ir_distance,
   input  logic [DIST_W-1:0]  req_sonar_distance,
   input  logic [DIST_W-1:0]  near_threshold,
   input  logic [STEP_W-1:0]  angle_step,
   input  logic               queue_full,
   output logic               push,
   output job_type            push_job
);

   det_state_type      state_ff, state_in, state_cur;
   logic [ANGLE_W-1:0] begin_ff, begin_in, begin_cur;
   logic [SUM_W-1:0]   sum_ff, sum_in, sum_cur, sum_acc;
   logic [COUNT_W-1:0] count_ff, count_in, count_cur, count_acc;
   logic [FOUND_W-1:0] found_ff, found_in, found_cur;
   logic               accept, is_near, is_far, end_object;
   logic [ANGLE_W-1:0] last_angle;

   // stall only on a full queue
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // detector next state
   always_comb begin
      state_cur = state_ff;
      begin_cur = begin_ff;
      sum_cur   = sum_ff;
      count_cur = count_ff;
      found_cur = found_ff;
      if (req_sweep_start) begin
         state_cur = DET_IDLE;
         begin_cur = '0;
         sum_cur   = '0;
         count_cur = '0;
         found_cur = '0;
      end

      is_near = (req_ir_distance < near_threshold) && (req_sonar_distance < near_threshold);
      is_far  = (req_ir_distance > near_threshold) || (req_sonar_distance > near_threshold);

      // accumulate until the count is full
      if (count_cur < COUNT_MAX) begin
         sum_acc   = sum_cur + SUM_W'(req_sonar_distance);
         count_acc = count_cur + COUNT_W'(1);
      end else begin
         sum_acc   = sum_cur;
         count_acc = count_cur;
      end

      last_angle = (req_angle >= ANGLE_W'(angle_step)) ?
                   req_angle - ANGLE_W'(angle_step) : '0;

      state_in   = state_cur;
      begin_in   = begin_cur;
      sum_in     = sum_cur;
      count_in   = count_cur;
      found_in   = found_cur;
      end_object = 1'b0;

      if (is_near) begin
         unique case (state_cur)
            DET_IDLE, DET_REJECTED, DET_ENDED: begin
               state_in = DET_FIRST;
               begin_in = req_angle;
               sum_in   = sum_acc;
               count_in = count_acc;
            end
            DET_FIRST: begin
               state_in = DET_SECOND;
               sum_in   = sum_acc;
               count_in = count_acc;
            end
            DET_SECOND: begin
               state_in = DET_COUNTED;
               sum_in   = sum_acc;
               count_in = count_acc;
               found_in = (found_cur < FOUND_MAX) ? found_cur + FOUND_W'(1) : found_cur;
            end
            DET_COUNTED, DET_CONTINUE: begin
               state_in = DET_CONTINUE;
               sum_in   = sum_acc;
               count_in = count_acc;
            end
            default: begin
               state_in = state_cur;
            end
         endcase
      end else if (is_far) begin
         unique case (state_cur)
            DET_FIRST, DET_SECOND: begin
               state_in = (found_cur == '0) ? DET_IDLE : DET_REJECTED;
               sum_in   = '0;
               count_in = '0;
            end
            DET_COUNTED, DET_CONTINUE: begin
               state_in   = DET_ENDED;
               sum_in     = '0;
               count_in   = '0;
               end_object = 1'b1;
            end
            default: begin
               state_in = state_cur;
            end
         endcase
      end
   end

   // job for the back end
   assign push               = accept && end_object;
   assign push_job.found     = found_cur;
   assign push_job.last      = last_angle;
   assign push_job.run_begin = begin_cur;
   assign push_job.sum       = sum_cur;
   assign push_job.count     = count_cur;

   // detector registers, updated per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DET_IDLE;
         begin_ff <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         found_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         begin_ff <= begin_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

endmodule

/* hw/rtl/sos_queue.sv */
// ----------------------------------------------------------------------------
// sos_queue
// Short job queue between the detector front and the arithmetic back end.
// ----------------------------------------------------------------------------
module sos_queue import sos_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/sos_divider.sv */
// ----------------------------------------------------------------------------
// sos_divider
// Restoring divider, one quotient bit per cycle. The numerator is shifted in
// from its top bit; after the given number of steps the quotient sits in
// the low bits of the quotient word.
// ----------------------------------------------------------------------------
module sos_divider import sos_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_NUM_W-1:0]  numerator,
   input  logic [DIV_DEN_W-1:0]  denominator,
   input  logic [DIV_STEP_W-1:0] steps,
   output logic                  done,
   output logic [DIV_NUM_W-1:0]  quotient
);

   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DIV_STEP_W-1:0] left_ff, left_in;
   logic [DIV_NUM_W-1:0]  num_ff, num_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [DIV_DEN_W:0]    rem_shift;
   logic                  fits, last_step;

   assign done     = done_ff;
   assign quotient = num_ff;

   // one trial subtract per cycle
   always_comb begin
      rem_shift = {rem_ff, num_ff[DIV_NUM_W-1]};
      fits      = (rem_shift >= {1'b0, den_ff});
      last_step = busy_ff && (left_ff == DIV_STEP_W'(1));

      busy_in = busy_ff;
      done_in = last_step;
      left_in = left_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         left_in = steps;
         num_in  = numerator;
         rem_in  = '0;
         den_in  = denominator;
      end else if (busy_ff) begin
         busy_in = !last_step;
         left_in = left_ff - DIV_STEP_W'(1);
         num_in  = {num_ff[DIV_NUM_W-2:0], fits};
         rem_in  = fits ? DIV_DEN_W'(rem_shift - {1'b0, den_ff}) : rem_shift[DIV_DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

/* hw/rtl/sos_back.sv */
// ----------------------------------------------------------------------------
// sos_back
// Takes one object job at a time: center, size, mean distance through the
// serial divider, then, for sizes on the table, tangent of half the size
// through the same divider and width by one multiply; then the result register.
// ----------------------------------------------------------------------------
module sos_back import sos_pkg::*; #(
   parameter int TAN_ENTRIES = 91
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  job_type            job,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FOUND_W-1:0] rsp_object_number,
   output logic [ANGLE_W-1:0] rsp_center_angle,
   output logic [ANGLE_W-1:0] rsp_angular_size,
   output logic [DIST_W-1:0]  rsp_mean_distance,
   output logic [DIST_W-1:0]  rsp_object_width
);

   localparam int IdxW = $clog2(TAN_ENTRIES);

   typedef logic [TRIG_W-1:0] trig_col_type [TAN_ENTRIES];

   // unit vector rotated by half a degree per entry, Q30
   function automatic trig_col_type build_trig(input logic want_sin);
      logic [63:0]  c;
      logic [63:0]  s;
      logic [63:0]  nc;
      logic [63:0]  ns;
      trig_col_type col;
      int           k;
      c = ONE_Q30;
      s = '0;
      for (k = 0; k < TAN_ENTRIES; k++) begin
         col[k] = want_sin ? s[TRIG_W-1:0] : c[TRIG_W-1:0];
         nc = (c * COS_HALF_Q30 + ROUND_Q30) >> Q30_SHIFT;
         ns = (s * SIN_HALF_Q30 + ROUND_Q30) >> Q30_SHIFT;
         nc = (nc > ns) ? nc - ns : 64'd0;
         ns = ((s * COS_HALF_Q30 + ROUND_Q30) >> Q30_SHIFT) +
              ((c * SIN_HALF_Q30 + ROUND_Q30) >> Q30_SHIFT);
         c  = nc;
         s  = ns;
      end
      return col;
   endfunction

   localparam trig_col_type SIN_ROM = build_trig(1'b1);
   localparam trig_col_type COS_ROM = build_trig(1'b0);

   back_state_type        state_ff, state_in;
   logic [FOUND_W-1:0]    number_ff, number_in;
   logic [ANGLE_W-1:0]    center_ff, center_in, size_ff, size_in;
   logic                  zero_count_ff, zero_count_in, off_table_ff, off_table_in;
   logic [DIST_W-1:0]     mean_ff, mean_in, width_ff, width_in;
   logic [TAN_W-1:0]      tan_ff, tan_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FOUND_W-1:0]    rsp_number_ff;
   logic [ANGLE_W-1:0]    rsp_center_ff, rsp_size_ff;
   logic [DIST_W-1:0]     rsp_mean_ff, rsp_width_ff;
   logic                  rsp_load, slot_free;

   logic                  div_start, div_done;
   logic [DIV_NUM_W-1:0]  div_num, div_quo;
   logic [DIV_DEN_W-1:0]  div_den;
   logic [DIV_STEP_W-1:0] div_steps;

   logic [ANGLE_W:0]      center_sum;
   logic [ANGLE_W-1:0]    job_size;
   logic                  job_off;
   logic [IdxW-1:0]       tan_idx;
   logic [TRIG_W-1:0]     sin_sel, cos_sel;
   logic [SUM_W-1:0]      mean_quo;
   logic [DIST_W-1:0]     mean_value, width_sat;

   sos_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .steps       (div_steps),
      .done        (div_done),
      .quotient    (div_quo)
   );

   // job geometry
   always_comb begin
      center_sum = {1'b0, job.last} + {1'b0, job.run_begin};
      job_size   = (job.last >= job.run_begin) ? job.last - job.run_begin : '0;
      job_off    = (job_size >= SIZE_LIMIT) || (int'(job_size) >= TAN_ENTRIES);
   end

   // table lookup, divide and width results
   always_comb begin
      tan_idx    = size_ff[IdxW-1:0];
      sin_sel    = SIN_ROM[tan_idx];
      cos_sel    = COS_ROM[tan_idx];
      mean_quo   = div_quo[SUM_W-1:0];
      if (zero_count_ff) begin
         mean_value = '0;
      end else if (|mean_quo[SUM_W-1:DIST_W]) begin
         mean_value = '1;
      end else begin
         mean_value = mean_quo[DIST_W-1:0];
      end
      // (2 * mean * tan) >> 16 == product >> 15
      if (|prod_ff[PROD_W-1:DIST_W+FRAC_SHIFT-1]) begin
         width_sat = '1;
      end else begin
         width_sat = prod_ff[DIST_W+FRAC_SHIFT-2:FRAC_SHIFT-1];
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // sequencer next state and outputs
   always_comb begin
      state_in      = state_ff;
      number_in     = number_ff;
      center_in     = center_ff;
      size_in       = size_ff;
      zero_count_in = zero_count_ff;
      off_table_in  = off_table_ff;
      mean_in       = mean_ff;
      tan_in        = tan_ff;
      prod_in       = prod_ff;
      width_in      = width_ff;
      job_pop       = 1'b0;
      div_start     = 1'b0;
      div_num       = {job.sum, {(DIV_NUM_W - SUM_W){1'b0}}};
      div_den       = DIV_DEN_W'(job.count);
      div_steps     = MEAN_STEPS;
      rsp_load      = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop       = 1'b1;
               div_start     = 1'b1;
               number_in     = job.found;
               center_in     = center_sum[ANGLE_W:1];
               size_in       = job_size;
               zero_count_in = (job.count == '0);
               off_table_in  = job_off;
               state_in      = BK_MEAN;
            end
         end
         BK_MEAN: begin
            div_num   = {sin_sel[TRIG_W-2:0], {FRAC_SHIFT{1'b0}}};
            div_den   = cos_sel;
            div_steps = TAN_STEPS;
            if (div_done) begin
               mean_in = mean_value;
               if (off_table_ff) begin
                  width_in = '1;
                  state_in = BK_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = BK_TAN;
               end
            end
         end
         BK_TAN: begin
            if (div_done) begin
               tan_in   = div_quo[TAN_W-1:0];
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            prod_in  = PROD_W'(mean_ff) * PROD_W'(tan_ff);
            state_in = BK_WIDTH;
         end
         BK_WIDTH: begin
            width_in = width_sat;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      number_ff     <= number_in;
      center_ff     <= center_in;
      size_ff       <= size_in;
      zero_count_ff <= zero_count_in;
      off_table_ff  <= off_table_in;
      mean_ff       <= mean_in;
      tan_ff        <= tan_in;
      prod_ff       <= prod_in;
      width_ff      <= width_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_number_ff <= number_ff;
         rsp_center_ff <= center_ff;
         rsp_size_ff   <= size_ff;
         rsp_mean_ff   <= mean_ff;
         rsp_width_ff  <= width_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_object_number = rsp_number_ff;
   assign rsp_center_angle  = rsp_center_ff;
   assign rsp_angular_size  = rsp_size_ff;
   assign rsp_mean_distance = rsp_mean_ff;
   assign rsp_object_width  = rsp_width_ff;

endmodule

/* hw/rtl/sweep_object_segmenter.sv */
// ----------------------------------------------------------------------------
// sweep_object_segmenter
// Finds objects in a servo sweep and reports center, size, mean distance
// and linear width of each.
// ----------------------------------------------------------------------------
// A sample beat is taken every clock cycle while the two-entry object queue
// has room; the detector classifies it and updates its run state in that
// cycle. A beat that ends an object leaves a job in the queue, and the back
// end turns each job into one result beat: the shared bit-serial divider
// for the mean distance, then again for the tangent quotient (skipped when
// the size is off the tangent table), one multiply, one saturation step and
// the load of the result register. The back end takes a new job only once
// the last one is through, and req_stall rises only when two objects wait
// behind the one in progress.
// The tangent table is built at elaboration; there is no start-up pass.
// Configuration writes are taken in any cycle and belong in idle periods.
// ----------------------------------------------------------------------------
module sweep_object_segmenter import sos_pkg::*; #(
   parameter int TAN_ENTRIES = 91
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_sweep_start,
   input  logic [ANGLE_W-1:0]     req_angle,
   input  logic [DIST_W-1:0]      req_ir_distance,
   input  logic [DIST_W-1:0]      req_sonar_distance,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FOUND_W-1:0]     rsp_object_number,
   output logic [ANGLE_W-1:0]     rsp_center_angle,
   output logic [ANGLE_W-1:0]     rsp_angular_size,
   output logic [DIST_W-1:0]      rsp_mean_distance,
   output logic [DIST_W-1:0]      rsp_object_width,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [DIST_W-1:0] near_threshold_ff, near_threshold_in;
   logic [STEP_W-1:0] angle_step_ff, angle_step_in;
   logic              push, queue_full, head_valid, job_pop;
   job_type           push_job, head_job;

   // configuration registers
   always_comb begin
      near_threshold_in = near_threshold_ff;
      angle_step_in     = angle_step_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_NEAR_THRESHOLD: near_threshold_in = csr_wdata[DIST_W-1:0];
            CSR_ANGLE_STEP:     angle_step_in     = csr_wdata[STEP_W-1:0];
            default:            near_threshold_in = near_threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_threshold_ff <= THRESHOLD_RESET;
         angle_step_ff     <= STEP_RESET;
      end else begin
         near_threshold_ff <= near_threshold_in;
         angle_step_ff     <= angle_step_in;
      end
   end

   // detector front
   sos_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sweep_start    (req_sweep_start),
      .req_angle          (req_angle),
      .req_ir_distance    (req_ir_distance),
      .req_sonar_distance (req_sonar_distance),
      .near_threshold     (near_threshold_ff),
      .angle_step         (angle_step_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_job           (push_job)
   );

   // object job queue
   sos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // arithmetic back end
   sos_back #(
      .TAN_ENTRIES (TAN_ENTRIES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (head_valid),
      .job               (head_job),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_object_number (rsp_object_number),
      .rsp_center_angle  (rsp_center_angle),
      .rsp_angular_size  (rsp_angular_size),
      .rsp_mean_distance (rsp_mean_distance),
      .rsp_object_width  (rsp_object_width)
   );

endmodule

/* hw/rtl/sos_checker.sv */
// ----------------------------------------------------------------------------
// sos_checker
// Port-level checks of the sweep object segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module sos_checker import sos_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [FOUND_W-1:0]     rsp_object_number,
   input logic [ANGLE_W-1:0]     rsp_center_angle,
   input logic [ANGLE_W-1:0]     rsp_angular_size,
   input logic [DIST_W-1:0]      rsp_mean_distance,
   input logic [DIST_W-1:0]      rsp_object_width
);

   // a stalled result beat holds its width, mean distance and object number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_object_width) &&
                                 $stable(rsp_mean_distance) && $stable(rsp_object_number))
      else $error("stalled result beat changed");

   // every reported object has been counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_object_number != '0)
      else $error("object number zero");

   // sizes of SIZE_LIMIT and above saturate the width
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_angular_size >= SIZE_LIMIT |-> rsp_object_width == '1)
      else $error("off-table size without saturated width");

   // the center lies at least half the size above zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_angle >= (rsp_angular_size >> 1))
      else $error("center angle below half the size");

   // zero distance gives zero width for sizes below 46
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mean_distance == '0 && rsp_angular_size < 8'd46 |->
      rsp_object_width == '0)
      else $error("width without distance");

endmodule

bind sweep_object_segmenter sos_checker u_sos_checker (.*);
